// ----- design/prsd_pkg.sv -----
// ----------------------------------------------------------------------------
// prsd_pkg
// Shared types and codes for the per-source packet rate detector.
// ----------------------------------------------------------------------------
`default_nettype none

package prsd_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_TARGET    = 3'd0;
    localparam logic [2:0] CFG_BASE_RATE = 3'd1;
    localparam logic [2:0] CFG_ICMP_LIM  = 3'd2;
    localparam logic [2:0] CFG_UDP_LIM   = 3'd3;
    localparam logic [2:0] CFG_TCP_LIM   = 3'd4;
    localparam logic [2:0] CFG_SIG_MASK  = 3'd5;

    // Opcodes of an input transaction
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Protocol classes
    localparam logic [1:0] CLASS_OTHER = 2'd0;
    localparam logic [1:0] CLASS_ICMP  = 2'd1;
    localparam logic [1:0] CLASS_UDP   = 2'd2;
    localparam logic [1:0] CLASS_TCP   = 2'd3;

    // Signature mask bits
    localparam int SIG_BIT_ICMP = 0;
    localparam int SIG_BIT_UDP  = 1;
    localparam int SIG_BIT_TCP  = 2;

    // Result kinds
    localparam logic [2:0] KIND_COUNTED      = 3'd0;
    localparam logic [2:0] KIND_PACKET_ALERT = 3'd1;
    localparam logic [2:0] KIND_WINDOW_ALERT = 3'd2;
    localparam logic [2:0] KIND_BACK_NORMAL  = 3'd3;
    localparam logic [2:0] KIND_WINDOW_QUIET = 3'd4;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_TARGET = 32'd0;
    localparam logic [15:0] RST_LIMIT  = 16'd20;
    localparam logic [2:0]  RST_MASK   = 3'd0;

    localparam logic [15:0] REPORT_MAX = 16'hFFFF;

    // One transaction as it travels down the cell chain
    typedef struct packed {
        logic        valid;
        logic        tick;
        logic [31:0] key;
        logic [1:0]  pclass;
        logic        known;
        logic [15:0] threshold;
        logic        done;
    } t_item;

endpackage

`default_nettype wire

// ----- design/prsd_cell.sv -----
// ----------------------------------------------------------------------------
// prsd_cell
// One table entry of the source counter chain; matches, counts or inserts
// the passing transaction, drops its entry on a tick, and hands it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module prsd_cell #(
    parameter int COUNT_BITS = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_advance,
    input  prsd_pkg::t_item        i_item,
    input  wire [COUNT_BITS-1:0]   i_count,
    output prsd_pkg::t_item        o_item,
    output logic [COUNT_BITS-1:0]  o_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic                  r_ent_valid, n_ent_valid;
    logic [31:0]           r_ent_addr,  n_ent_addr;
    logic [COUNT_BITS-1:0] r_ent_count, n_ent_count;
    prsd_pkg::t_item       r_item,      n_item;
    logic [COUNT_BITS-1:0] r_count,     n_count;

    logic                  w_hit;
    logic [COUNT_BITS-1:0] w_inc;

    assign w_hit = r_ent_valid && (r_ent_addr == i_item.key);
    assign w_inc = (&r_ent_count) ? r_ent_count : r_ent_count + COUNT_ONE;

    always_comb begin
        n_item      = i_item;
        n_count     = i_count;
        n_ent_valid = r_ent_valid;
        n_ent_addr  = r_ent_addr;
        n_ent_count = r_ent_count;
        if (i_item.valid) begin
            if (i_item.tick) begin
                // pick up the target's count; every entry is dropped, hit or not
                if (!i_item.done && w_hit) begin
                    n_item.done = 1'b1;
                    n_count     = r_ent_count;
                end
                n_ent_valid = 1'b0;
            end else if (!i_item.done) begin
                if (w_hit) begin
                    n_ent_count = w_inc;
                    n_count     = w_inc;
                    n_item.done = 1'b1;
                end else if (!r_ent_valid) begin
                    // first free entry: valid entries always form a prefix
                    n_ent_valid = 1'b1;
                    n_ent_addr  = i_item.key;
                    n_ent_count = COUNT_ONE;
                    n_count     = COUNT_ONE;
                    n_item.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
            r_item      <= '0;
        end else if (i_advance) begin
            r_ent_valid <= n_ent_valid;
            r_item      <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_ent_addr  <= n_ent_addr;
            r_ent_count <= n_ent_count;
            r_count     <= n_count;
        end
    end

    assign o_item  = r_item;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- design/per_source_packet_rate_detector.sv -----
// ----------------------------------------------------------------------------
// per_source_packet_rate_detector
// Counts packets per source address for a monitored target, raises packet
// alerts over a threshold and checks for a window alert on each window tick.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+--------------------------------------
//  input    | i_valid / o_stall        | opcode, source_ip, dest_ip, ip_proto
//  output   | o_valid / i_stall        | result_kind, reported_address,
//           |                          | current_count, protocol_class,
//           |                          | signature_known, table_full
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  A transaction walks the chain of TABLE_ENTRIES cell registers and then the
//  output register, which raises o_valid. The chain is fully pipelined: one
//  transaction per cycle is taken while the output side keeps up. Reset
//  clears every entry's valid bit, the chain, the attack flag and the
//  configuration registers at once; no clearing pass is needed. A stall on
//  the output freezes the whole chain and is passed back as o_stall.
//
`default_nettype none

module per_source_packet_rate_detector #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COUNT_BITS    = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,

    // input transactions
    input  wire          i_valid,
    output logic         o_stall,
    input  wire          i_opcode,
    input  wire [31:0]   i_source_ip,
    input  wire [31:0]   i_dest_ip,
    input  wire [7:0]    i_ip_proto,

    // result transactions
    output logic         o_valid,
    input  wire          i_stall,
    output logic [2:0]   o_result_kind,
    output logic [31:0]  o_reported_address,
    output logic [15:0]  o_current_count,
    output logic [1:0]   o_protocol_class,
    output logic         o_signature_known,
    output logic         o_table_full,

    // configuration writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [2:0]    i_cfg_index,
    input  wire [31:0]   i_cfg_data
);

    // Width that holds 2*count and 3*base_rate without overflow
    localparam int CMP_W = (COUNT_BITS + 2 > 18) ? COUNT_BITS + 2 : 18;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] r_target;
    logic [15:0] r_base_rate;
    logic [15:0] r_icmp_lim;
    logic [15:0] r_udp_lim;
    logic [15:0] r_tcp_lim;
    logic [2:0]  r_sig_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= prsd_pkg::RST_TARGET;
            r_base_rate <= prsd_pkg::RST_LIMIT;
            r_icmp_lim  <= prsd_pkg::RST_LIMIT;
            r_udp_lim   <= prsd_pkg::RST_LIMIT;
            r_tcp_lim   <= prsd_pkg::RST_LIMIT;
            r_sig_mask  <= prsd_pkg::RST_MASK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                prsd_pkg::CFG_TARGET:    r_target    <= i_cfg_data;
                prsd_pkg::CFG_BASE_RATE: r_base_rate <= i_cfg_data[15:0];
                prsd_pkg::CFG_ICMP_LIM:  r_icmp_lim  <= i_cfg_data[15:0];
                prsd_pkg::CFG_UDP_LIM:   r_udp_lim   <= i_cfg_data[15:0];
                prsd_pkg::CFG_TCP_LIM:   r_tcp_lim   <= i_cfg_data[15:0];
                prsd_pkg::CFG_SIG_MASK:  r_sig_mask  <= i_cfg_data[2:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole chain moves when the output slot is free
    // ------------------------------------------------------------------
    logic w_advance;

    assign w_advance = !o_valid || !i_stall;
    assign o_stall   = !w_advance;

    // ------------------------------------------------------------------
    // Head: filter, class the protocol and pick the threshold
    // ------------------------------------------------------------------
    logic            w_accept;
    logic            w_related;
    logic [1:0]      w_pclass;
    logic            w_known;
    logic [15:0]     w_threshold;
    prsd_pkg::t_item w_head;

    assign w_accept  = i_valid && !o_stall;
    assign w_related = (i_source_ip == r_target) || (i_dest_ip == r_target);

    always_comb begin
        case (i_ip_proto)
            prsd_pkg::PROTO_ICMP: w_pclass = prsd_pkg::CLASS_ICMP;
            prsd_pkg::PROTO_UDP:  w_pclass = prsd_pkg::CLASS_UDP;
            prsd_pkg::PROTO_TCP:  w_pclass = prsd_pkg::CLASS_TCP;
            default:              w_pclass = prsd_pkg::CLASS_OTHER;
        endcase
    end

    always_comb begin
        w_known     = 1'b0;
        w_threshold = r_base_rate;
        case (w_pclass)
            prsd_pkg::CLASS_ICMP: begin
                if (r_sig_mask[prsd_pkg::SIG_BIT_ICMP]) begin
                    w_known     = 1'b1;
                    w_threshold = r_icmp_lim;
                end
            end
            prsd_pkg::CLASS_UDP: begin
                if (r_sig_mask[prsd_pkg::SIG_BIT_UDP]) begin
                    w_known     = 1'b1;
                    w_threshold = r_udp_lim;
                end
            end
            prsd_pkg::CLASS_TCP: begin
                if (r_sig_mask[prsd_pkg::SIG_BIT_TCP]) begin
                    w_known     = 1'b1;
                    w_threshold = r_tcp_lim;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_head      = '0;
        w_head.tick = (i_opcode == prsd_pkg::OP_TICK);
        if (w_head.tick) begin
            // a tick searches for the target and clears the table behind it
            w_head.valid = w_accept;
            w_head.key   = r_target;
        end else begin
            // drop packets that do not involve the target
            w_head.valid     = w_accept && w_related;
            w_head.key       = i_source_ip;
            w_head.pclass    = w_pclass;
            w_head.known     = w_known;
            w_head.threshold = w_threshold;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    prsd_pkg::t_item       w_item  [0:TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] w_count [0:TABLE_ENTRIES];

    assign w_item[0]  = w_head;
    assign w_count[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        prsd_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_item    (w_item[g]),
            .i_count   (w_count[g]),
            .o_item    (w_item[g+1]),
            .o_count   (w_count[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Tail: decide the result kind and track the attack flag
    // ------------------------------------------------------------------
    prsd_pkg::t_item       w_tail;
    logic [COUNT_BITS-1:0] w_tail_count;
    logic [CMP_W-1:0]      w_cnt_wide;
    logic [CMP_W-1:0]      w_thr_wide;
    logic [CMP_W-1:0]      w_base_wide;
    logic [CMP_W-1:0]      w_twice_cnt;
    logic [CMP_W-1:0]      w_thrice_base;
    logic [15:0]           w_report;

    logic                  r_attack, n_attack;
    logic [2:0]            n_kind;
    logic                  n_full;

    assign w_tail       = w_item[TABLE_ENTRIES];
    // a tick that found no target entry, or a packet with no room, reads zero
    assign w_tail_count = w_tail.done ? w_count[TABLE_ENTRIES] : '0;

    assign w_cnt_wide    = {{(CMP_W-COUNT_BITS){1'b0}}, w_tail_count};
    assign w_thr_wide    = {{(CMP_W-16){1'b0}}, w_tail.threshold};
    assign w_base_wide   = {{(CMP_W-16){1'b0}}, r_base_rate};
    assign w_twice_cnt   = {w_cnt_wide[CMP_W-2:0], 1'b0};
    assign w_thrice_base = {w_base_wide[CMP_W-2:0], 1'b0} + w_base_wide;
    assign w_report      = (w_cnt_wide > {{(CMP_W-16){1'b0}}, prsd_pkg::REPORT_MAX})
                           ? prsd_pkg::REPORT_MAX : w_cnt_wide[15:0];

    always_comb begin
        n_attack = r_attack;
        n_kind   = prsd_pkg::KIND_COUNTED;
        n_full   = 1'b0;
        if (w_tail.tick) begin
            if (w_twice_cnt > w_thrice_base) begin
                n_attack = 1'b1;
                n_kind   = prsd_pkg::KIND_WINDOW_ALERT;
            end else if (r_attack) begin
                n_attack = 1'b0;
                n_kind   = prsd_pkg::KIND_BACK_NORMAL;
            end else begin
                n_kind   = prsd_pkg::KIND_WINDOW_QUIET;
            end
        end else if (!w_tail.done) begin
            // no match and no free entry: flag it, no alert
            n_full = 1'b1;
        end else if (w_cnt_wide > w_thr_wide) begin
            n_attack = 1'b1;
            n_kind   = prsd_pkg::KIND_PACKET_ALERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= 1'b0;
            o_valid  <= 1'b0;
        end else if (w_advance) begin
            o_valid <= w_tail.valid;
            if (w_tail.valid) begin
                r_attack <= n_attack;
            end
        end
    end

    // Hold the result while stalled, load the next one on advance
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_result_kind      <= n_kind;
            o_reported_address <= w_tail.key;
            o_current_count    <= w_report;
            o_protocol_class   <= w_tail.pclass;
            o_signature_known  <= w_tail.known;
            o_table_full       <= n_full;
        end
    end

endmodule

`default_nettype wire
